/* rtl/core/fed_pkg.sv */
// Shared types, constants and helpers for the feedback echo delay.
// No dependencies; used by every other file of the block.
`default_nettype none

package fed_pkg;

  localparam int DELAY_LENGTH = 65536;
  localparam int SAMPLE_WIDTH = 24;
  localparam int ADDR_W       = $clog2(DELAY_LENGTH);
  localparam int GAIN_W       = 16;
  localparam int GAIN_SHIFT   = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // product of a sample and an unsigned gain, plus the shifted and summed forms
  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int SHR_W  = PROD_W - GAIN_SHIFT;
  localparam int SUM_W  = SHR_W + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [ADDR_W-1:0]       addr_t;
  typedef logic        [GAIN_W-1:0]       gain_t;

  localparam gain_t GAIN_ONE = gain_t'(1 << GAIN_SHIFT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_OFFSET = 2'd0,
    REG_WET_MIX     = 2'd1,
    REG_FEEDBACK    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic    en;
    addr_t   addr;
    sample_t data;
  } mem_wr_t;

  function automatic gain_t gain_clamp(input logic [CFG_DATA_W-1:0] g);
    gain_clamp = (g > CFG_DATA_W'(GAIN_ONE)) ? GAIN_ONE : gain_t'(g);
  endfunction

  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat_sample = sample_t'(hi);
    end else if (v < lo) begin
      sat_sample = sample_t'(lo);
    end else begin
      sat_sample = sample_t'(v);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fed_if.sv */
// Stream interfaces for sample beats in and out of the echo delay.
// Depends on fed_pkg for the sample type.
`default_nettype none

interface fed_in_if;
  logic             valid;
  logic             ready;
  fed_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fed_out_if;
  logic             valid;
  logic             ready;
  fed_pkg::sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/fed_delay_mem.sv */
// Circular delay memory: one write port, one read port with registered data.
// Depends on fed_pkg.
`default_nettype none

module fed_delay_mem (
  input  wire logic             clk,
  input  wire fed_pkg::mem_wr_t wr,
  input  wire logic             rd_en,
  input  wire fed_pkg::addr_t   rd_addr,
  output fed_pkg::sample_t      rd_data
);

  fed_pkg::sample_t mem [fed_pkg::DELAY_LENGTH];
  fed_pkg::sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/fed_blend.sv */
// Q1.15 two-way blend: registered products, then floor shift, add, saturate.
// Depends on fed_pkg.
`default_nettype none

module fed_blend (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire fed_pkg::sample_t delayed,
  input  wire fed_pkg::sample_t dry,
  input  wire fed_pkg::gain_t   gain,
  input  wire fed_pkg::gain_t   gain_c,
  output fed_pkg::sample_t      mix
);

  logic signed [fed_pkg::PROD_W-1:0] pa_nxt, pb_nxt, pa_r, pb_r;
  logic signed [fed_pkg::SHR_W-1:0]  sa, sb;
  logic signed [fed_pkg::SUM_W-1:0]  sum;

  always_comb begin
    pa_nxt = fed_pkg::PROD_W'(delayed) * fed_pkg::PROD_W'($signed({1'b0, gain}));
    pb_nxt = fed_pkg::PROD_W'(dry) * fed_pkg::PROD_W'($signed({1'b0, gain_c}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // arithmetic shift gives floor rounding
  always_comb begin
    sa  = fed_pkg::SHR_W'(pa_r >>> fed_pkg::GAIN_SHIFT);
    sb  = fed_pkg::SHR_W'(pb_r >>> fed_pkg::GAIN_SHIFT);
    sum = fed_pkg::SUM_W'(sa) + fed_pkg::SUM_W'(sb);
    mix = fed_pkg::sat_sample(sum);
  end

endmodule

`default_nettype wire

/* rtl/core/feedback_echo_delay.sv */
// Feedback echo over a 64K-entry circular delay memory, 24-bit samples.
// Path: an accepted beat passes stage 1, stage 2 and the result register to out_bus.
// Throughput: one beat per cycle while out_bus.ready holds; with read_offset 0 a beat
//   waits in stage 1 until the one before it, whose write-back it reads, leaves stage 2.
// Reset: synchronous, clears pointer, pipeline and history, loads default offset and
//   gains; no memory clear pass, a fill mark makes unwritten entries read as zero.
`default_nettype none

module feedback_echo_delay (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fed_in_if.sink                               in_bus,
  fed_out_if.source                            out_bus,
  input  wire logic                            cfg_we,
  input  wire logic [fed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fed_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // ---------------------------------------------------------------
  // Configuration: gains are stored clamped, with their complement
  // ---------------------------------------------------------------
  fed_pkg::addr_t offset_r;
  fed_pkg::gain_t wet_r, wet_c_r, fb_r, fb_c_r;
  fed_pkg::gain_t cfg_gain;

  assign cfg_gain = fed_pkg::gain_clamp(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= fed_pkg::addr_t'(52429);
      wet_r    <= fed_pkg::gain_t'(9830);
      wet_c_r  <= fed_pkg::GAIN_ONE - fed_pkg::gain_t'(9830);
      fb_r     <= fed_pkg::gain_t'(16384);
      fb_c_r   <= fed_pkg::GAIN_ONE - fed_pkg::gain_t'(16384);
    end else if (cfg_we) begin
      case (fed_pkg::cfg_idx_t'(cfg_index))
        fed_pkg::REG_READ_OFFSET: offset_r <= fed_pkg::addr_t'(cfg_data);
        fed_pkg::REG_WET_MIX: begin
          wet_r   <= cfg_gain;
          wet_c_r <= fed_pkg::GAIN_ONE - cfg_gain;
        end
        fed_pkg::REG_FEEDBACK: begin
          fb_r   <= cfg_gain;
          fb_c_r <= fed_pkg::GAIN_ONE - cfg_gain;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake and pipeline control
  //   s1: read data back, operand select, products computed
  //   s2: products held, sums formed, write-back issued
  //   out: result register
  // ---------------------------------------------------------------
  logic in_acc, s1_go, s2_go, s1_hold, out_take;
  logic s1_vld_r, s2_vld_r, out_vld_r;

  // Offset 0 reads the entry the previous sample writes back (one back).
  // Offset all-ones reads the entry written two samples back.
  logic off_one_back, off_two_back;
  assign off_one_back = (offset_r == '0);
  assign off_two_back = (offset_r == '1);

  assign out_take = out_vld_r && out_bus.ready;
  assign s2_go    = s2_vld_r && (!out_vld_r || out_bus.ready);
  assign s1_hold  = off_one_back && s2_vld_r;
  assign s1_go    = s1_vld_r && !s1_hold && (!s2_vld_r || s2_go);
  assign in_bus.ready = !s1_vld_r || s1_go;
  assign in_acc   = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        s2_vld_r <= 1'b1;
      end else if (s2_go) begin
        s2_vld_r <= 1'b0;
      end
      if (s2_go) begin
        out_vld_r <= 1'b1;
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Write pointer and fill mark. Writes walk up from entry 1, so an
  // entry holds data once the pointer has passed it, or after a wrap.
  // ---------------------------------------------------------------
  fed_pkg::addr_t wp_r, rd_addr;
  logic           full_r, rd_written;

  assign rd_addr    = wp_r + offset_r;
  assign rd_written = full_r || ((rd_addr != '0) && (rd_addr <= wp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (in_acc) begin
      wp_r <= wp_r + fed_pkg::addr_t'(1);
      if (wp_r == '1) begin
        full_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Delay memory
  // ---------------------------------------------------------------
  fed_pkg::mem_wr_t mem_wr;
  fed_pkg::sample_t rd_data;
  fed_pkg::sample_t fbv;

  fed_delay_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------
  // Stage 1 registers and operand select. Write-backs of the last two
  // samples may not have reached the memory by the read, so they come
  // from a two-deep history of written values.
  // ---------------------------------------------------------------
  fed_pkg::sample_t s1_x_r;
  fed_pkg::addr_t   s1_waddr_r, s2_waddr_r;
  logic             s1_written_r;
  fed_pkg::sample_t hist1_r, hist2_r;
  fed_pkg::sample_t delayed;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r       <= in_bus.sample_in;
      s1_waddr_r   <= wp_r + fed_pkg::addr_t'(1);
      s1_written_r <= rd_written;
    end
    if (s1_go) begin
      s2_waddr_r <= s1_waddr_r;
    end
  end

  always_comb begin
    if (off_one_back) begin
      delayed = hist1_r;
    end else if (off_two_back) begin
      delayed = s2_vld_r ? hist1_r : hist2_r;
    end else begin
      delayed = s1_written_r ? rd_data : '0;
    end
  end

  // ---------------------------------------------------------------
  // Blends: wet/dry output and feedback write-back
  // ---------------------------------------------------------------
  fed_pkg::sample_t wet_mix;

  fed_blend u_out_blend (
    .clk     (clk),
    .en      (s1_go),
    .delayed (delayed),
    .dry     (s1_x_r),
    .gain    (wet_r),
    .gain_c  (wet_c_r),
    .mix     (wet_mix)
  );

  fed_blend u_fb_blend (
    .clk     (clk),
    .en      (s1_go),
    .delayed (delayed),
    .dry     (s1_x_r),
    .gain    (fb_r),
    .gain_c  (fb_c_r),
    .mix     (fbv)
  );

  // ---------------------------------------------------------------
  // Stage 2 retire: write back, shift history, load result register
  // ---------------------------------------------------------------
  fed_pkg::sample_t out_data_r;

  always_comb begin
    mem_wr.en   = s2_go;
    mem_wr.addr = s2_waddr_r;
    mem_wr.data = fbv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist1_r <= '0;
      hist2_r <= '0;
    end else if (s2_go) begin
      hist1_r <= fbv;
      hist2_r <= hist1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r <= wet_mix;
    end
  end

  assign out_bus.valid      = out_vld_r;
  assign out_bus.sample_out = out_data_r;

`ifndef ASSERT_OFF
  a_wr_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |=> out_vld_r)
    else $error("write-back without a result beat");

  a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("fill mark dropped");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted beat lost at stage 1");

  a_one_back_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (off_one_back && s2_vld_r) |-> !s1_go)
    else $error("stage 1 advanced before prior write-back");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> s2_vld_r)
    else $error("beat lost between stages");
`endif

endmodule

`default_nettype wire

/* tb/sv/echo_scoreboard_pkg.sv */
// Scoreboard for the feedback echo delay. It keeps its own delay memory, write pointer
// and gain registers, and it checks output beats in order.
// Depends on fed_pkg.
package echo_scoreboard_pkg;
  import fed_pkg::*;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  localparam logic [CFG_DATA_W-1:0] OFFSET_AT_RESET   = 16'd52429;
  localparam logic [CFG_DATA_W-1:0] WET_AT_RESET      = 16'd9830;
  localparam logic [CFG_DATA_W-1:0] FEEDBACK_AT_RESET = 16'd16384;

  class echo_scoreboard;
    sample_t               delay_mem [DELAY_LENGTH];
    addr_t                 wr_ptr;
    logic [CFG_DATA_W-1:0] read_offset;
    logic [CFG_DATA_W-1:0] wet_gain;
    logic [CFG_DATA_W-1:0] fb_gain;
    sample_t               due_samples [$];
    int                    fails;

    function new();
      foreach (delay_mem[i]) delay_mem[i] = '0;
      wr_ptr      = '0;
      read_offset = OFFSET_AT_RESET;
      wet_gain    = WET_AT_RESET;
      fb_gain     = FEEDBACK_AT_RESET;
      fails       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_READ_OFFSET: read_offset = value;
        REG_WET_MIX:     wet_gain    = value;
        REG_FEEDBACK:    fb_gain     = value;
        default: ;
      endcase
    endfunction

    // delayed*g + dry*(1-g). The Q1.15 gain is clamped to 1.0. Each product is floored,
    // and the sum is saturated.
    function sample_t weigh(sample_t delayed, sample_t dry, logic [CFG_DATA_W-1:0] gain);
      longint g;
      longint sum;
      g   = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
      sum = ((longint'(delayed) * g) >>> GAIN_SHIFT)
          + ((longint'(dry) * (longint'(GAIN_ONE) - g)) >>> GAIN_SHIFT);
      if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
      if (sum < SAMPLE_MIN) sum = SAMPLE_MIN;
      return sample_t'(sum);
    endfunction

    // The read comes before the pointer advances and the feedback is written.
    // The 16-bit address sum wraps modulo DELAY_LENGTH.
    function void take_sample(sample_t x);
      addr_t   rd_addr;
      sample_t delayed;
      rd_addr = addr_t'(wr_ptr + read_offset);
      delayed = delay_mem[rd_addr];
      due_samples.push_back(weigh(delayed, x, wet_gain));
      wr_ptr  = addr_t'(wr_ptr + 1'b1);
      delay_mem[wr_ptr] = weigh(delayed, x, fb_gain);
    endfunction

    function void check_output(sample_t y);
      sample_t want;
      if (due_samples.size() == 0) begin
        $display("%0t: sample_out expected none, got %0d", $time, y);
        fails++;
      end else begin
        want = due_samples.pop_front();
        if (y !== want) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want, y);
          fails++;
        end
      end
    endfunction
  endclass

endpackage

/* tb/sv/feedback_echo_delay_tb.sv */
// Top-level testbench for feedback_echo_delay. It runs directed and random sample beats
// under varying handshake stalls and checks every output against echo_scoreboard.
// Depends on fed_pkg, fed_if and echo_scoreboard_pkg.
module feedback_echo_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fed_pkg::*;
  import echo_scoreboard_pkg::*;

  // index 3 is not a register; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int      WATCHDOG_LIMIT = 5000;  // cycles with no beat on either side
  localparam int      SETTLE_CYCLES  = 4;     // covers the pipeline plus write-back
  localparam int      RANDOM_BEATS   = 930;
  localparam sample_t S_MAX          = sample_t'(SAMPLE_MAX);
  localparam sample_t S_MIN          = sample_t'(SAMPLE_MIN);

  // idle percentages per stall profile: receiver-heavy, sender-heavy, none
  localparam int SRC_IDLE [3] = '{28, 84, 0};
  localparam int SNK_IDLE [3] = '{84, 28, 0};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fed_in_if  in_bus ();
  fed_out_if out_bus ();

  echo_scoreboard sb;
  int             src_idle_pct;
  int             snk_idle_pct;
  int             quiet_cycles;

  feedback_echo_delay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver and watchdog. Everything here is sampled at the edge, before any NBA
  // update, so reads see the values from before the edge. ready is re-rolled once
  // per cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) sb.check_output(out_bus.sample_out);
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Presents one sample beat and returns on the edge that accepts it.
  // valid stays high afterwards. The next call lowers it only if it rolls an idle,
  // so valid never gets two NBAs in one step.
  task automatic send_beat(input sample_t x);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    do @(posedge clk); while (!in_bus.ready);
    sb.take_sample(x);
  endtask

  // Stops sending and waits until every beat has come out.
  // Then it waits a few more cycles so that the last write-back has landed.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back writes. cfg_we is set high by each write and lowered only after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] offset,
                           input logic [CFG_DATA_W-1:0] wet,
                           input logic [CFG_DATA_W-1:0] fb);
    write_reg(REG_READ_OFFSET, offset);
    write_reg(REG_WET_MIX, wet);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Samples: full-scale extremes, values near zero, and raw 24-bit noise.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return sample_t'($signed($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Gains: both ends, values above one (clamped), and the legal Q1.15 range.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return GAIN_ONE;
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(32769, 65535));
      default: return CFG_DATA_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // Most offsets are just under the length, so reads hit entries written a few beats
  // back and the echo builds up. Zero reads the previous write-back. One reads the
  // entry that the next write will overwrite.
  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'(1);
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'(DELAY_LENGTH - $urandom_range(2, 48));
    endcase
  endfunction

  initial begin
    int profile;
    int sent;
    int run_len;

    sb               = new();
    src_idle_pct     = SRC_IDLE[0];
    snk_idle_pct     = SNK_IDLE[0];
    quiet_cycles     = 0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the read lands far ahead on cleared entries, so the output is
    // the dry path alone.
    send_beat(S_MAX);
    send_beat(S_MIN);
    send_beat('0);
    send_beat(-1);
    send_beat(1);

    // Offset zero: each beat reads the write-back of the beat before it. The wet gain
    // is above one and clamps, so the output is the delayed sample itself.
    drain();
    load_regs('0, '1, 16'd16384);
    send_beat(S_MIN);
    send_beat(S_MIN);
    send_beat(S_MAX);
    send_beat(S_MAX);
    send_beat(S_MIN + 1);
    send_beat(5);

    // Maximum offset wraps to one entry behind. Feedback is exactly one, so the
    // memory only recirculates.
    drain();
    load_regs('1, 16'd16384, GAIN_ONE);
    send_beat(S_MAX);
    send_beat(S_MIN);
    send_beat(-1);
    send_beat(S_MAX);
    send_beat(S_MIN);
    send_beat('0);

    // The read hits the entry about to be written, so it sees the old content. Dry
    // output only; feedback is just above one.
    drain();
    load_regs(CFG_DATA_W'(1), '0, 16'h8001);
    send_beat(S_MAX);
    send_beat(S_MIN);
    send_beat(3);
    send_beat(-3);

    // Random runs. Each run gets fresh settings, and every stall profile takes
    // a third of the beats.
    for (profile = 0; profile < 3; profile++) begin
      src_idle_pct = SRC_IDLE[profile];
      snk_idle_pct = SNK_IDLE[profile];
      sent = 0;
      while (sent < RANDOM_BEATS / 3) begin
        drain();
        load_regs(pick_offset(), pick_gain(), pick_gain());
        run_len = $urandom_range(20, 60);
        repeat (run_len) send_beat(pick_sample());
        sent += run_len;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.due_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
